@@ hdl/ttr_pkg.sv @@
// ----------------------------------------------------------------------------
// ttr_pkg
// Shared types, command codes and helpers for the touch tap relay toggler.
// ----------------------------------------------------------------------------
package ttr_pkg;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_ESTOP  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ON_MIN      = 2'd0,
        CFG_ON_MAX      = 2'd1,
        CFG_ENABLE_MASK = 2'd2,
        CFG_MANUAL_CH   = 2'd3
    } t_cfg_idx;

    localparam int CNT_W  = 8;
    localparam int CH_W   = 3;
    localparam int CFG_W  = 8;
    localparam int IN_W   = 8;

    localparam logic [CNT_W-1:0] ON_MIN_RST    = 8'd5;
    localparam logic [CNT_W-1:0] ON_MAX_RST    = 8'd30;
    localparam logic [CFG_W-1:0] EN_MASK_RST   = 8'd31;
    localparam logic [CH_W-1:0]  MANUAL_CH_RST = 3'd4;

    // Tap timing limits handed to every channel lane.
    typedef struct packed {
        logic [CNT_W-1:0] on_min;
        logic [CNT_W-1:0] on_max;
    } t_tap_cfg;

    // Saturating increment of a sample counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

@@ hdl/ttr_lane.sv @@
// ----------------------------------------------------------------------------
// ttr_lane
// Tap qualifier for one touch channel: step and sample counters, next state.
// ----------------------------------------------------------------------------
module ttr_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sel,      // a sample for this channel is taken
    input  logic              i_on,
    input  ttr_pkg::t_tap_cfg i_cfg,
    output logic              o_tap       // sample completes a tap
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ON_DET,
        ST_ON_STABLE,
        ST_OFF_DET
    } t_step;

    t_step                      r_step, n_step;
    logic [ttr_pkg::CNT_W-1:0]  r_on_cnt, n_on_cnt;
    logic [ttr_pkg::CNT_W-1:0]  r_off_cnt, n_off_cnt;
    logic [ttr_pkg::CNT_W-1:0]  w_on_inc, w_on_inc2, w_off_inc;
    logic                       w_in_range;

    assign w_on_inc   = ttr_pkg::sat_inc(r_on_cnt);
    assign w_on_inc2  = ttr_pkg::sat_inc(w_on_inc);
    assign w_off_inc  = ttr_pkg::sat_inc(r_off_cnt);
    assign w_in_range = (r_on_cnt >= i_cfg.on_min) && (r_on_cnt <= i_cfg.on_max);

    // The passing steps (off stable, act) have no state of their own: the sample that
    // reaches them runs through to idle within the same item.
    always_comb begin
        n_step    = r_step;
        n_on_cnt  = r_on_cnt;
        n_off_cnt = r_off_cnt;
        o_tap     = 1'b0;
        if (i_sel) begin
            case (r_step)
                ST_IDLE, ST_ON_DET, ST_OFF_DET: begin
                    if (i_on) begin
                        if (r_step == ST_OFF_DET) begin
                            n_off_cnt = '0;
                        end
                        if (w_on_inc < i_cfg.on_min) begin
                            n_step   = ST_ON_DET;
                            n_on_cnt = w_on_inc;
                        end else begin
                            // Stable on is re-evaluated with the same sample.
                            n_step   = ST_ON_STABLE;
                            n_on_cnt = w_on_inc2;
                        end
                    end else if (r_step == ST_ON_DET) begin
                        n_step   = ST_IDLE;
                        n_on_cnt = '0;
                    end else if (r_step == ST_OFF_DET) begin
                        if (w_off_inc < i_cfg.on_min) begin
                            n_off_cnt = w_off_inc;
                        end else begin
                            n_off_cnt = '0;
                            n_step    = ST_IDLE;
                            o_tap     = 1'b1;
                        end
                    end
                end
                ST_ON_STABLE: begin
                    if (i_on) begin
                        n_on_cnt = w_on_inc;
                    end else begin
                        n_on_cnt = '0;
                        if (!w_in_range) begin
                            n_step = ST_IDLE;
                        end else if (w_off_inc < i_cfg.on_min) begin
                            n_step    = ST_OFF_DET;
                            n_off_cnt = w_off_inc;
                        end else begin
                            n_step    = ST_IDLE;
                            n_off_cnt = '0;
                            o_tap     = 1'b1;
                        end
                    end
                end
                default: begin
                    n_step = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_on_cnt  <= '0;
            r_off_cnt <= '0;
        end else begin
            r_step    <= n_step;
            r_on_cnt  <= n_on_cnt;
            r_off_cnt <= n_off_cnt;
        end
    end

endmodule

@@ hdl/touch_tap_relay_toggler_top.sv @@
// ----------------------------------------------------------------------------
// touch_tap_relay_toggler_top
// Per-channel touch tap qualifier driving a bank of relays.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle and its result appears in the output
// register on the next cycle; the block keeps accepting while that result is
// being taken. Each touch channel has its own lane of step and counter
// registers, and a sample is fully qualified in the cycle it is accepted, so
// the throughput is one item per cycle whenever the output side is ready.
// Relay states are reported after every item, including direct writes and the
// emergency stop, which clears all relays.
module touch_tap_relay_toggler_top #(
    parameter int RELAYS         = 4,
    parameter int TOUCH_CHANNELS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item: cmd[1:0], channel[4:2], sensor_on[5], relay_value[6], pad[7]
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ttr_pkg::IN_W-1:0]      i_s_axis_tdata,
    // Result: relay_states[RELAYS-1:0], toggled, manual_request, bad_channel,
    // then zero padding to a whole byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [((RELAYS+10)/8)*8-1:0]  o_m_axis_tdata,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [ttr_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int MAX_CH = 8;
    localparam logic [3:0] RELAYS_L = 4'(RELAYS);
    localparam logic [3:0] TOUCH_L  = 4'(TOUCH_CHANNELS);

    // Configuration registers.
    ttr_pkg::t_tap_cfg               r_tap_cfg;
    logic [ttr_pkg::CFG_W-1:0]       r_en_mask;
    logic [ttr_pkg::CH_W-1:0]        r_manual_ch;

    logic [RELAYS-1:0]               r_relay, n_relay;
    logic                            r_out_valid;
    logic                            r_tog, r_man, r_bad;
    logic                            n_tog, n_man, n_bad;

    logic                            w_accept;
    ttr_pkg::t_cmd                   w_cmd;
    logic [ttr_pkg::CH_W-1:0]        w_ch;
    logic                            w_on;
    logic                            w_level;
    logic [MAX_CH-1:0]               w_sel;
    logic [MAX_CH-1:0]               w_tap;
    logic                            w_tap_any;
    logic                            w_is_relay;
    logic                            w_is_touch;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_cmd   = ttr_pkg::t_cmd'(i_s_axis_tdata[1:0]);
    assign w_ch    = i_s_axis_tdata[4:2];
    assign w_on    = i_s_axis_tdata[5];
    assign w_level = i_s_axis_tdata[6];

    assign w_is_relay = {1'b0, w_ch} < RELAYS_L;
    assign w_is_touch = {1'b0, w_ch} < TOUCH_L;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_cfg.on_min <= ttr_pkg::ON_MIN_RST;
            r_tap_cfg.on_max <= ttr_pkg::ON_MAX_RST;
            r_en_mask        <= ttr_pkg::EN_MASK_RST;
            r_manual_ch      <= ttr_pkg::MANUAL_CH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ttr_pkg::t_cfg_idx'(i_cfg_index))
                ttr_pkg::CFG_ON_MIN:      r_tap_cfg.on_min <= i_cfg_data;
                ttr_pkg::CFG_ON_MAX:      r_tap_cfg.on_max <= i_cfg_data;
                ttr_pkg::CFG_ENABLE_MASK: r_en_mask        <= i_cfg_data;
                ttr_pkg::CFG_MANUAL_CH:   r_manual_ch      <= i_cfg_data[ttr_pkg::CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One lane per touch channel; lanes beyond the channel count read as idle.
    for (genvar g = 0; g < MAX_CH; g++) begin : g_lane
        if (g < TOUCH_CHANNELS) begin : g_on
            assign w_sel[g] = w_accept && (w_cmd == ttr_pkg::CMD_SAMPLE)
                              && (w_ch == 3'(g)) && r_en_mask[g];
            ttr_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_sel   (w_sel[g]),
                .i_on    (w_on),
                .i_cfg   (r_tap_cfg),
                .o_tap   (w_tap[g])
            );
        end else begin : g_off
            assign w_sel[g] = 1'b0;
            assign w_tap[g] = 1'b0;
        end
    end

    assign w_tap_any = |w_tap;

    always_comb begin
        n_relay = r_relay;
        n_tog   = 1'b0;
        n_man   = 1'b0;
        n_bad   = 1'b0;
        case (w_cmd)
            ttr_pkg::CMD_SAMPLE: begin
                if (!w_is_touch) begin
                    n_bad = 1'b1;
                end else if (w_tap_any) begin
                    // A relay channel always toggles, even if it is the manual one.
                    n_relay = r_relay ^ w_tap[RELAYS-1:0];
                    n_tog   = w_is_relay;
                    n_man   = !w_is_relay && (w_ch == r_manual_ch);
                    n_bad   = !w_is_relay && (w_ch != r_manual_ch);
                end
            end
            ttr_pkg::CMD_WRITE: begin
                if (!w_is_relay) begin
                    n_bad = 1'b1;
                end else begin
                    for (int r = 0; r < RELAYS; r++) begin
                        if (w_ch == 3'(r)) begin
                            n_relay[r] = w_level;
                        end
                    end
                end
            end
            ttr_pkg::CMD_ESTOP: begin
                n_relay = '0;
            end
            default: begin
            end
        endcase
    end

    // r_relay only changes when an item is accepted, which also loads the
    // output register, so it always matches the result being presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_relay     <= n_relay;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tog <= n_tog;
            r_man <= n_man;
            r_bad <= n_bad;
        end
    end

    always_comb begin
        o_m_axis_tdata             = '0;
        o_m_axis_tdata[RELAYS-1:0] = r_relay;
        o_m_axis_tdata[RELAYS]     = r_tog;
        o_m_axis_tdata[RELAYS+1]   = r_man;
        o_m_axis_tdata[RELAYS+2]   = r_bad;
    end

    assign o_m_axis_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_one_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tap))
        else $error("more than one channel completed a tap");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_tog && r_man) && !(r_tog && r_bad))
        else $error("conflicting result flags");

    a_estop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_cmd == ttr_pkg::CMD_ESTOP) |=> (r_relay == '0))
        else $error("relays not cleared by emergency stop");

    a_toggle_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_cmd == ttr_pkg::CMD_SAMPLE)
        |=> ((r_relay != $past(r_relay)) == r_tog))
        else $error("toggled flag disagrees with relay change");
`endif

endmodule
